/* rtl/calendar_alarm_table_assert.svh */
// Assertion macros shared by the alarm table RTL.
`ifndef CALENDAR_ALARM_TABLE_ASSERT_SVH
`define CALENDAR_ALARM_TABLE_ASSERT_SVH

// The condition must hold in every cycle in which the trigger is high.
`define CAT_ASSERT_IMP(lbl, clk, rst_n, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// The two conditions are never high in the same cycle.
`define CAT_ASSERT_EXCL(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> !(b)) \
        else $error(msg);

`endif

/* rtl/cat_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cat_pkg: shared definitions of the calendar alarm table
// Request and response codes, flag bits, the stored entry layout and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package cat_pkg;

    localparam int DEF_TABLE_DEPTH = 16;

    localparam int IN_TDATA_W  = 72;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 16;
    localparam int OUT_TUSER_W = 3;

    typedef logic [1:0] t_req;
    typedef logic [2:0] t_kind;

    localparam t_req REQ_TICK = 2'd0;
    localparam t_req REQ_ADD  = 2'd1;
    localparam t_req REQ_DEL  = 2'd2;

    localparam t_kind KIND_FIRED     = 3'd0;
    localparam t_kind KIND_ADDED     = 3'd1;
    localparam t_kind KIND_FULL      = 3'd2;
    localparam t_kind KIND_DELETED   = 3'd3;
    localparam t_kind KIND_NOT_FOUND = 3'd4;
    localparam t_kind KIND_TICK_DONE = 3'd5;

    localparam int FLAG_ENABLED = 0;
    localparam int FLAG_ONESHOT = 1;
    localparam int FLAG_USER    = 2;
    localparam int WILDCARD_BIT = 7;

    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  week;
        logic [7:0]  hour;
        logic [7:0]  minute;
        logic [7:0]  second;
        logic [2:0]  flags;
    } t_entry;

    typedef struct packed {
        logic  in_ready;
        logic  load;
        logic  start_walk;
        logic  step;
        logic  finish_walk;
        logic  add_write;
        logic  out_load;
        t_kind out_kind;
    } t_cmd;

    typedef struct packed {
        t_req req;
        logic walk_done;
        logic hit;
        logic found;
        logic full;
        logic out_free;
    } t_status;

endpackage

/* rtl/cat_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cat_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/cat_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cat_ctrl: sequencer of the calendar alarm table
// Takes one request, dispatches it, walks the table entry by entry for
// ticks and deletes, and schedules every result beat.
// ----------------------------------------------------------------------------
module cat_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  cat_pkg::t_status i_status,
    output cat_pkg::t_cmd    o_cmd
);
    import cat_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DISP = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_EV   = 3'd3;
    localparam logic [2:0] S_END  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_cmd       cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        cmd      = '0;
        n_state  = r_state;
        case (r_state)
            S_IDLE: begin
                cmd.in_ready = 1'b1;
                cmd.load     = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                case (i_status.req)
                    REQ_TICK, REQ_DEL: begin
                        cmd.start_walk = 1'b1;
                        n_state        = S_RD;
                    end
                    REQ_ADD: begin
                        if (i_status.out_free) begin
                            cmd.out_load = 1'b1;
                            if (i_status.full) begin
                                cmd.out_kind = KIND_FULL;
                            end else begin
                                cmd.out_kind  = KIND_ADDED;
                                cmd.add_write = 1'b1;
                            end
                            n_state = S_IDLE;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_RD: begin
                // The read address is already on the RAM; its data shows next cycle.
                n_state = i_status.walk_done ? S_END : S_EV;
            end
            S_EV: begin
                if (i_status.req == REQ_TICK && i_status.hit) begin
                    if (i_status.out_free) begin
                        cmd.out_load = 1'b1;
                        cmd.out_kind = KIND_FIRED;
                        cmd.step     = 1'b1;
                        n_state      = S_RD;
                    end
                end else begin
                    cmd.step = 1'b1;
                    n_state  = S_RD;
                end
            end
            S_END: begin
                if (i_status.out_free) begin
                    cmd.finish_walk = 1'b1;
                    cmd.out_load    = 1'b1;
                    if (i_status.req == REQ_TICK) begin
                        cmd.out_kind = KIND_TICK_DONE;
                    end else if (i_status.found) begin
                        cmd.out_kind = KIND_DELETED;
                    end else begin
                        cmd.out_kind = KIND_NOT_FOUND;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_cmd = cmd;

endmodule

/* rtl/cat_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cat_dp: datapath of the calendar alarm table
// Holds the request register, table pointers, count and id counter, the
// match logic, the in-place compaction writes and the result register.
// ----------------------------------------------------------------------------
module cat_dp #(
    parameter int TABLE_DEPTH = cat_pkg::DEF_TABLE_DEPTH,
    parameter int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    parameter int CW = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  cat_pkg::t_cmd                    i_cmd,
    output cat_pkg::t_status                 o_status,
    input  logic [cat_pkg::IN_TDATA_W-1:0]   i_in_tdata,
    input  logic [cat_pkg::IN_TUSER_W-1:0]   i_in_tuser,
    output logic                             o_ram_we,
    output logic [AW-1:0]                    o_ram_waddr,
    output cat_pkg::t_entry                  o_ram_wdata,
    output logic [AW-1:0]                    o_ram_raddr,
    input  cat_pkg::t_entry                  i_ram_rdata,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [cat_pkg::OUT_TDATA_W-1:0]  o_out_tdata,
    output logic [cat_pkg::OUT_TUSER_W-1:0]  o_out_tuser,
    output logic                             o_out_tlast
);
    import cat_pkg::*;

    // Request register, loaded on the accepted input beat.
    logic [IN_TDATA_W-1:0] r_data;
    t_req                  r_req;

    logic [CW-1:0] r_rd;
    logic [CW-1:0] r_wr;
    logic [CW-1:0] r_count;
    logic          r_found;
    logic [15:0]   r_id_ctr;

    logic          r_out_valid;
    logic [15:0]   r_out_id;
    t_kind         r_out_kind;
    logic          r_out_last;

    logic [2:0]  now_wday;
    logic [4:0]  now_hour;
    logic [5:0]  now_min;
    logic [5:0]  now_sec;
    logic [15:0] target;
    logic [15:0] next_id;
    t_entry      e;
    t_entry      new_entry;
    logic        hit;
    logic        del_hit;
    logic        remove;
    logic        keep_write;
    logic        out_free;

    assign now_wday = r_data[2:0];
    assign now_hour = r_data[7:3];
    assign now_min  = r_data[13:8];
    assign now_sec  = r_data[19:14];
    assign target   = r_data[70:55];
    assign next_id  = r_id_ctr + 16'd1;

    assign new_entry.id     = next_id;
    assign new_entry.week   = r_data[27:20];
    assign new_entry.hour   = r_data[35:28];
    assign new_entry.minute = r_data[43:36];
    assign new_entry.second = r_data[51:44];
    assign new_entry.flags  = r_data[54:52];

    assign e = i_ram_rdata;

    assign hit = e.flags[FLAG_ENABLED]
               && (e.week[WILDCARD_BIT] || e.week[now_wday])
               && (e.hour[WILDCARD_BIT] || e.hour == {3'b000, now_hour})
               && (e.minute[WILDCARD_BIT] || e.minute == {2'b00, now_min})
               && (e.second[WILDCARD_BIT] || e.second == {2'b00, now_sec});

    // Only the first qualifying entry goes away on a delete.
    assign del_hit = !r_found && e.flags[FLAG_USER] && e.id == target;

    assign remove = (r_req == REQ_TICK) ? (hit && e.flags[FLAG_ONESHOT]) : del_hit;
    assign keep_write = i_cmd.step && !remove;

    assign o_ram_we    = i_cmd.add_write || keep_write;
    assign o_ram_waddr = i_cmd.add_write ? r_count[AW-1:0] : r_wr[AW-1:0];
    assign o_ram_wdata = i_cmd.add_write ? new_entry : e;
    assign o_ram_raddr = r_rd[AW-1:0];

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_data <= i_in_tdata;
            r_req  <= i_in_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd     <= '0;
            r_wr     <= '0;
            r_count  <= '0;
            r_found  <= 1'b0;
            r_id_ctr <= '0;
        end else begin
            if (i_cmd.start_walk) begin
                r_rd    <= '0;
                r_wr    <= '0;
                r_found <= 1'b0;
            end
            if (i_cmd.step) begin
                r_rd <= r_rd + 1'b1;
                if (!remove) begin
                    r_wr <= r_wr + 1'b1;
                end
                if (r_req == REQ_DEL && del_hit) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.finish_walk) begin
                r_count <= r_wr;
            end
            if (i_cmd.add_write) begin
                r_count  <= r_count + 1'b1;
                r_id_ctr <= next_id;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_kind <= i_cmd.out_kind;
            r_out_last <= (i_cmd.out_kind != KIND_FIRED);
            case (i_cmd.out_kind)
                KIND_FIRED:   r_out_id <= e.id;
                KIND_ADDED:   r_out_id <= next_id;
                KIND_DELETED: r_out_id <= target;
                default:      r_out_id <= '0;
            endcase
        end
    end

    assign o_status.req       = r_req;
    assign o_status.walk_done = (r_rd == r_count);
    assign o_status.hit       = hit;
    assign o_status.found     = r_found;
    assign o_status.full      = (r_count == CW'(TABLE_DEPTH));
    assign o_status.out_free  = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_tdata = r_out_id;
    assign o_out_tuser = r_out_kind;
    assign o_out_tlast = r_out_last;

endmodule

/* rtl/calendar_alarm_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_alarm_table: ordered table of calendar alarms
// Appends alarm entries, fires matching entries on each tick and removes
// fired one-shot entries in place, and deletes user-deletable entries by id.
// ----------------------------------------------------------------------------
//  Channel  Dir  Beat carries
//  s_axis   in   one request: add entry, delete by id, or tick
//  m_axis   out  one result: fired, added, full, deleted, not found, tick done
//
//  Add: the dispatch state loads the result beat once the output is free.
//  Delete and tick: each stored entry takes a read state on the single RAM
//  read port and an evaluate state for the registered data.
//  One request is worked at a time; the next is taken once the last result
//  is in the output register. A stalled output holds the walk in place.
//  Reset clears the entry count and id counter; no clearing pass is needed.
// ----------------------------------------------------------------------------
module calendar_alarm_table #(
    parameter int TABLE_DEPTH = cat_pkg::DEF_TABLE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata from bit 0: now_weekday[3], now_hour[5], now_minute[6],
    // now_second[6], match_week[8], match_hour[8], match_minute[8],
    // match_second[8], entry_flags[3], target_id[16], zero pad[1]
    input  logic [cat_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser: req_type[2]
    input  logic [cat_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata: entry_id[16]
    output logic [cat_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // tuser: resp_kind[3]
    output logic [cat_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
    output logic                            m_axis_tlast
);
    import cat_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    t_cmd          cmd;
    t_status       status;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    t_entry        ram_wdata;
    t_entry        ram_rdata;

    cat_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    cat_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW),
        .CW          (CW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_tdata  (s_axis_tdata),
        .i_in_tuser  (s_axis_tuser),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_tdata (m_axis_tdata),
        .o_out_tuser (m_axis_tuser),
        .o_out_tlast (m_axis_tlast)
    );

    cat_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign s_axis_tready = cmd.in_ready;

`include "calendar_alarm_table_assert.svh"

    `CAT_ASSERT_IMP(a_no_result_overwrite, i_clk, i_rst_n, cmd.out_load, status.out_free,
                    "result register overwritten while a beat is pending")
    `CAT_ASSERT_IMP(a_add_not_full, i_clk, i_rst_n, cmd.add_write, !status.full,
                    "entry appended to a full table")
    `CAT_ASSERT_EXCL(a_no_walk_on_accept, i_clk, i_rst_n, cmd.in_ready, cmd.step,
                     "table walk running while requests are accepted")
    `CAT_ASSERT_EXCL(a_step_in_range, i_clk, i_rst_n, cmd.step, status.walk_done,
                     "walk stepped past the last entry")

endmodule

/* tb/sv/tb_calendar_alarm_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_calendar_alarm_table: self-checking bench for the calendar alarm table
// Drives add, delete and tick requests through the input stream and checks
// every result beat against a behavioral copy of the table kept in the bench.
// Covers the full table, protected entries, wildcards, weekday seven and
// random traffic with stalls on both sides.
// ----------------------------------------------------------------------------
module tb_calendar_alarm_table;
    import cat_pkg::*;

    localparam int DEPTH = DEF_TABLE_DEPTH;
    localparam int QUIET_LIMIT = 1000;
    localparam t_req REQ_UNUSED = 2'd3;
    localparam logic [2:0] F_EN  = 3'(1 << FLAG_ENABLED);
    localparam logic [2:0] F_ONE = 3'(1 << FLAG_ONESHOT);
    localparam logic [2:0] F_USR = 3'(1 << FLAG_USER);
    localparam logic [7:0] ANY   = 8'(1 << WILDCARD_BIT);

    typedef struct packed {
        t_req        req;
        logic [2:0]  wday;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [7:0]  m_week;
        logic [7:0]  m_hour;
        logic [7:0]  m_minute;
        logic [7:0]  m_second;
        logic [2:0]  flags;
        logic [15:0] target;
    } t_request;

    typedef struct {
        t_kind       kind;
        logic [15:0] id;
        logic        last;
    } t_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [OUT_TUSER_W-1:0] m_axis_tuser;
    logic                   m_axis_tlast;

    // Bench copy of the alarm table and the results it predicts.
    t_entry      alarm_tab [DEPTH];
    int unsigned alarm_cnt = 0;
    logic [15:0] last_id = '0;
    t_result     expected_results [$];

    bit          idle_on = 1'b1;
    int unsigned fail_cnt = 0;
    int unsigned quiet_cycles = 0;
    int unsigned req_cnt = 0;
    int unsigned rx_hold = 0;
    int unsigned kind_seen [6] = '{default: 0};

    calendar_alarm_table uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit byte_hits(logic [7:0] want, logic [7:0] now);
        return want[WILDCARD_BIT] || want == now;
    endfunction

    function automatic void unlink_alarm(int unsigned pos);
        for (int unsigned i = pos; i + 1 < alarm_cnt; i++)
            alarm_tab[i] = alarm_tab[i + 1];
        alarm_cnt--;
    endfunction

    function automatic void push_result(t_kind kind, logic [15:0] id, logic last);
        t_result r;
        r.kind = kind;
        r.id   = id;
        r.last = last;
        expected_results.push_back(r);
    endfunction

    function automatic void predict_request(t_request rq);
        int unsigned i;
        bit hit;
        bit done;
        case (rq.req)
            REQ_TICK: begin
                i = 0;
                while (i < alarm_cnt) begin
                    hit = alarm_tab[i].flags[FLAG_ENABLED] &&
                          (alarm_tab[i].week[WILDCARD_BIT] || alarm_tab[i].week[rq.wday]) &&
                          byte_hits(alarm_tab[i].hour, 8'(rq.hour)) &&
                          byte_hits(alarm_tab[i].minute, 8'(rq.minute)) &&
                          byte_hits(alarm_tab[i].second, 8'(rq.second));
                    if (hit)
                        push_result(KIND_FIRED, alarm_tab[i].id, 1'b0);
                    // A fired one-shot leaves; the next entry slides into slot i.
                    if (hit && alarm_tab[i].flags[FLAG_ONESHOT])
                        unlink_alarm(i);
                    else
                        i++;
                end
                push_result(KIND_TICK_DONE, '0, 1'b1);
            end
            REQ_ADD: begin
                if (alarm_cnt >= DEPTH) begin
                    push_result(KIND_FULL, '0, 1'b1);
                end else begin
                    last_id = last_id + 16'd1;
                    alarm_tab[alarm_cnt] = '{last_id, rq.m_week, rq.m_hour, rq.m_minute,
                                             rq.m_second, rq.flags};
                    alarm_cnt++;
                    push_result(KIND_ADDED, last_id, 1'b1);
                end
            end
            REQ_DEL: begin
                done = 1'b0;
                for (int unsigned k = 0; k < alarm_cnt && !done; k++) begin
                    if (alarm_tab[k].flags[FLAG_USER] && alarm_tab[k].id == rq.target) begin
                        unlink_alarm(k);
                        push_result(KIND_DELETED, rq.target, 1'b1);
                        done = 1'b1;
                    end
                end
                if (!done)
                    push_result(KIND_NOT_FOUND, '0, 1'b1);
            end
            default: ;
        endcase
    endfunction

    // Every field starts as noise; callers overwrite the ones the request uses.
    function automatic t_request random_request();
        logic [95:0] noise;
        noise = {$urandom(), $urandom(), $urandom()};
        return noise[$bits(t_request)-1:0];
    endfunction

    task automatic send_request(input t_request rq);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= rq.req;
        s_axis_tdata  <= {1'b0, rq.target, rq.flags, rq.m_second, rq.m_minute, rq.m_hour,
                          rq.m_week, rq.second, rq.minute, rq.hour, rq.wday};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_request(rq);
        req_cnt++;
    endtask

    task automatic add_alarm(input logic [7:0] wk, input logic [7:0] hr,
                             input logic [7:0] mn, input logic [7:0] sc,
                             input logic [2:0] fl);
        t_request rq;
        rq = random_request();
        rq.req      = REQ_ADD;
        rq.m_week   = wk;
        rq.m_hour   = hr;
        rq.m_minute = mn;
        rq.m_second = sc;
        rq.flags    = fl;
        send_request(rq);
    endtask

    task automatic delete_alarm(input logic [15:0] id);
        t_request rq;
        rq = random_request();
        rq.req    = REQ_DEL;
        rq.target = id;
        send_request(rq);
    endtask

    task automatic send_tick(input logic [2:0] wd, input logic [4:0] hr,
                             input logic [5:0] mn, input logic [5:0] sc);
        t_request rq;
        rq = random_request();
        rq.req    = REQ_TICK;
        rq.wday   = wd;
        rq.hour   = hr;
        rq.minute = mn;
        rq.second = sc;
        send_request(rq);
    endtask

    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    task automatic test_basic_requests();
        logic [15:0] id_a, id_b, id_c;
        t_request rq;
        delete_alarm(16'd0);
        send_tick(3'd0, 5'd0, 6'd0, 6'd0);
        add_alarm(8'h02, 8'd23, 8'd59, 8'd60, F_EN | F_USR);
        id_a = last_id;
        add_alarm(8'hFF, 8'hFF, 8'hFF, 8'hFF, F_EN | F_ONE);
        id_b = last_id;
        add_alarm(8'h7F, 8'h00, 8'h00, 8'h00, F_USR);
        id_c = last_id;
        add_alarm(ANY, ANY, ANY, 8'd5, F_EN | F_ONE | F_USR);
        // The all-wildcard one-shot lacks the user flag, so it cannot be deleted.
        delete_alarm(id_b);
        send_tick(3'd1, 5'd23, 6'd59, 6'd60);
        // Weekday seven only reaches entries whose weekday mask is a wildcard.
        send_tick(3'd7, 5'd0, 6'd0, 6'd5);
        send_tick(3'd0, 5'd0, 6'd0, 6'd0);
        delete_alarm(id_a);
        delete_alarm(id_c);
        delete_alarm(16'hFFFF);
        rq = random_request();
        rq.req = REQ_UNUSED;
        send_request(rq);
        send_tick(3'd6, 5'd31, 6'd63, 6'd63);
    endtask

    task automatic test_table_full();
        for (int i = 0; i < DEPTH; i++)
            add_alarm((i % 2) ? (ANY | 8'($urandom)) : (8'h08 | 8'($urandom_range(0, 127))),
                      (i % 3 == 0) ? (ANY | 8'($urandom)) : 8'd10,
                      (i % 4 == 1) ? 8'd30 : (ANY | 8'($urandom)),
                      (i % 5 == 2) ? (ANY | 8'($urandom)) : 8'd45,
                      F_EN | F_ONE | (i[0] ? F_USR : 3'b000));
        add_alarm(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'b111);
        add_alarm(8'h00, 8'h00, 8'h00, 8'h00, 3'b000);
        delete_alarm(16'hFFFF);
        // Hold the sender off until the table has answered everything so far.
        wait_results_drained();
        send_tick(3'd3, 5'd10, 6'd30, 6'd45);
    endtask

    task automatic test_random_traffic(input int unsigned count, input bit idling);
        t_request rq;
        t_entry pick_e;
        int unsigned sent;
        int unsigned pick;
        idle_on = idling;
        sent = 0;
        while (sent < count) begin
            rq = random_request();
            pick = $urandom_range(0, 99);
            if (pick < 36) begin
                rq.req = REQ_ADD;
                rq.m_week   = ($urandom_range(0, 3) == 0) ? (ANY | rq.m_week)
                                                        : 8'($urandom_range(0, 127));
                rq.m_hour   = ($urandom_range(0, 3) == 0) ? (ANY | rq.m_hour)
                                                        : 8'($urandom_range(0, 23));
                rq.m_minute = ($urandom_range(0, 3) == 0) ? (ANY | rq.m_minute)
                                                        : 8'($urandom_range(0, 59));
                rq.m_second = ($urandom_range(0, 3) == 0) ? (ANY | rq.m_second)
                                                        : 8'($urandom_range(0, 60));
                if ($urandom_range(0, 7) == 0)
                    rq.m_hour = 8'($urandom);
                if ($urandom_range(0, 3) != 0)
                    rq.flags[FLAG_ENABLED] = 1'b1;
            end else if (pick < 60) begin
                rq.req = REQ_DEL;
                if (alarm_cnt > 0 && $urandom_range(0, 3) != 0)
                    rq.target = alarm_tab[$urandom_range(0, alarm_cnt - 1)].id;
            end else if (pick < 96) begin
                rq.req    = REQ_TICK;
                rq.wday   = 3'($urandom_range(0, 7));
                rq.hour   = 5'($urandom_range(0, 23));
                rq.minute = 6'($urandom_range(0, 59));
                rq.second = 6'($urandom_range(0, 60));
                // Half the ticks aim at a stored entry so that alarms really fire.
                if (alarm_cnt > 0 && $urandom_range(0, 1) == 0) begin
                    pick_e = alarm_tab[$urandom_range(0, alarm_cnt - 1)];
                    for (int k = 0; k < 7; k++)
                        if (pick_e.week[k] && $urandom_range(0, 1) == 0)
                            rq.wday = 3'(k);
                    if (!pick_e.hour[WILDCARD_BIT])
                        rq.hour = pick_e.hour[4:0];
                    if (!pick_e.minute[WILDCARD_BIT])
                        rq.minute = pick_e.minute[5:0];
                    if (!pick_e.second[WILDCARD_BIT])
                        rq.second = pick_e.second[5:0];
                end
            end else begin
                rq.req = REQ_UNUSED;
            end
            send_request(rq);
            if (rq.req != REQ_UNUSED)
                sent++;
        end
    endtask

    // Result side: random backpressure and the check of each beat.
    always @(posedge i_clk) begin
        t_result want;
        if (m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $error("Result beat with nothing expected: resp_kind %0d entry_id %0d",
                       m_axis_tuser, m_axis_tdata);
                fail_cnt++;
            end else begin
                want = expected_results.pop_front();
                kind_seen[want.kind]++;
                if (m_axis_tuser !== want.kind) begin
                    $error("resp_kind mismatch: expected %0d, got %0d", want.kind, m_axis_tuser);
                    fail_cnt++;
                end
                if (m_axis_tdata !== want.id) begin
                    $error("entry_id mismatch: expected %0d, got %0d", want.id, m_axis_tdata);
                    fail_cnt++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last mismatch: expected %0d, got %0d", want.last, m_axis_tlast);
                    fail_cnt++;
                end
            end
        end
        if (rx_hold > 0) begin
            rx_hold--;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            rx_hold = $urandom_range(0, 4);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Watchdog: no beat for %0d cycles, %0d results outstanding",
                     quiet_cycles, expected_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_basic_requests();
        test_table_full();
        test_random_traffic(210, 1'b1);
        test_random_traffic(60, 1'b0);
        wait_results_drained();
        repeat (20) @(posedge i_clk);
        $display("%0d requests: directed cases, a full table, protected entries, random mix.",
                 req_cnt);
        $display("Results: %0d fired, %0d added, %0d full, %0d deleted, %0d not found, %0d ticks.",
                 kind_seen[KIND_FIRED], kind_seen[KIND_ADDED], kind_seen[KIND_FULL],
                 kind_seen[KIND_DELETED], kind_seen[KIND_NOT_FOUND], kind_seen[KIND_TICK_DONE]);
        if (fail_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
